// ----- rtl/gslcc_pkg.sv -----
package gslcc_pkg;

    // Field widths of the stream words
    localparam int unsigned COORD_W     = 32;
    localparam int unsigned CELL_IDX_W  = 9;
    localparam int unsigned IN_LABEL_W  = 16;
    localparam int unsigned COUNT_W     = 10;
    localparam int unsigned IN_TDATA_W  = 168;
    localparam int unsigned IN_TUSER_W  = 1;
    localparam int unsigned OUT_TDATA_W = 16;

    // Configuration port
    localparam int unsigned CFG_AW  = 5;
    localparam int unsigned CFG_DW  = 32;
    localparam int unsigned LIMIT_W = 10;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Item kinds carried in tuser
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_WALK  = 1'b1;

    typedef enum logic [2:0] {
        REG_X_ORIGIN  = 3'd0,
        REG_Y_ORIGIN  = 3'd1,
        REG_INV_CELL  = 3'd2,
        REG_GRID_ROWS = 3'd3,
        REG_GRID_COLS = 3'd4
    } t_reg_idx;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SUB,
        S_MUL,
        S_CLAMP,
        S_CMP,
        S_LOAD,
        S_WALK,
        S_DONE
    } t_state;

endpackage

// ----- rtl/grid_segment_label_change_count_top.sv -----
// Channel  | Dir | Handshake              | Payload
// ---------+-----+------------------------+------------------------------------------
// s_axis   | in  | tvalid / tready        | tdata: row, col, label, start/end x/y
//          |     |                        | tuser: op (write or walk)
// m_axis   | out | tvalid / tready        | tdata: change_count
// apb      | in  | psel, penable, pwrite  | paddr / pwdata / prdata, pready tied high
//
// A write word stores the label on acceptance, then loads a zero result.
// A walk word: acceptance, four endpoint mappings through one shared subtract / 32x32
// multiply / clamp unit, a compare, a start-cell read, a walk of up to GRID_DIM - 1 steps
// at one grid read a cycle, done. Equal end cells go from the compare straight to done.
// After reset, clear the grid one entry a cycle with
// s_axis_tready low; a finished word holds in done while the result register stays full.
module grid_segment_label_change_count_top #(
    parameter int GRID_DIM   = 512,
    parameter int LABEL_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // lsb first: cell_row[8:0], cell_col[17:9], label[33:18], start_x[65:34],
    // start_y[97:66], end_x[129:98], end_y[161:130], zero pad[167:162]
    input  logic [gslcc_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // lsb first: op[0]
    input  logic [gslcc_pkg::IN_TUSER_W-1:0]    s_axis_tuser,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // lsb first: change_count[9:0], zero pad[15:10]
    output logic [gslcc_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [gslcc_pkg::CFG_AW-1:0]        paddr,
    input  logic [gslcc_pkg::CFG_DW-1:0]        pwdata,
    output logic [gslcc_pkg::CFG_DW-1:0]        prdata,
    output logic                                pready
);
    import gslcc_pkg::*;

    localparam int IW        = $clog2(GRID_DIM);
    localparam int AW        = 2 * IW;
    localparam int MEM_DEPTH = 1 << AW;

    // Configuration registers
    logic [COORD_W-1:0]  r_x_origin;
    logic [COORD_W-1:0]  r_y_origin;
    logic [COORD_W-1:0]  r_inv_cell;
    logic [LIMIT_W-1:0]  r_grid_rows;
    logic [LIMIT_W-1:0]  r_grid_cols;

    // Control
    t_state              r_state;
    t_state              n_state;
    logic [AW-1:0]       r_clr;
    logic [1:0]          r_ep;

    // Held walk endpoints
    logic [COORD_W-1:0]  r_sx;
    logic [COORD_W-1:0]  r_sy;
    logic [COORD_W-1:0]  r_ex;
    logic [COORD_W-1:0]  r_ey;

    // Shared mapping unit
    logic [COORD_W-1:0]  r_diff;
    logic                r_neg;
    logic [2*COORD_W-1:0] r_prod;

    // Mapped cells
    logic [IW-1:0]       r_c1;
    logic [IW-1:0]       r_r1;
    logic [IW-1:0]       r_c2;
    logic [IW-1:0]       r_r2;

    // Walk
    logic                r_along;
    logic [IW-1:0]       r_pos;
    logic [IW-1:0]       r_stop;
    logic                r_dv;
    logic                r_dfirst;
    logic                n_dv;
    logic                n_dfirst;
    logic [LABEL_BITS-1:0] r_rdata;
    logic [LABEL_BITS-1:0] r_last;
    logic [COUNT_W-1:0]  r_count;

    // Output register
    logic                r_ov;
    logic [COUNT_W-1:0]  r_out_count;

    // Grid memory
    logic [LABEL_BITS-1:0] r_grid [0:MEM_DEPTH-1];

    logic                w_in_acc;
    logic                w_cfg_wr;
    t_reg_idx            w_cfg_idx;
    logic [LIMIT_W-1:0]  w_rows_lim;
    logic [LIMIT_W-1:0]  w_cols_lim;
    logic                w_dims_zero;
    logic [COORD_W-1:0]  w_coord;
    logic [COORD_W-1:0]  w_origin;
    logic [COORD_W:0]    w_diff;
    logic [2*COORD_W-1:0] w_prod;
    logic [47:0]         w_q;
    logic [LIMIT_W-1:0]  w_lim;
    logic [IW-1:0]       w_idx;
    logic                w_cells_eq;
    logic [IW-1:0]       w_step;
    logic [IW-1:0]       w_rd_pos;
    logic [AW-1:0]       w_raddr;
    logic                w_we;
    logic [AW-1:0]       w_waddr;
    logic [LABEL_BITS-1:0] w_wdata;
    logic [LABEL_BITS-1:0] w_in_label;
    logic                w_wr_ok;
    logic                w_out_free;
    logic [COUNT_W:0]    w_sum;
    logic [COUNT_W-1:0]  w_count_sat;

    // ---------------------------------------------------------------- config port
    assign pready    = 1'b1;
    assign w_cfg_wr  = psel & penable & pwrite & pready;
    assign w_cfg_idx = t_reg_idx'(paddr[CFG_AW-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_origin  <= '0;
            r_y_origin  <= '0;
            r_inv_cell  <= 32'd65536;
            r_grid_rows <= 10'd512;
            r_grid_cols <= 10'd512;
        end else if (w_cfg_wr) begin
            unique case (w_cfg_idx)
                REG_X_ORIGIN:  r_x_origin  <= pwdata;
                REG_Y_ORIGIN:  r_y_origin  <= pwdata;
                REG_INV_CELL:  r_inv_cell  <= pwdata;
                REG_GRID_ROWS: r_grid_rows <= pwdata[LIMIT_W-1:0];
                REG_GRID_COLS: r_grid_cols <= pwdata[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_cfg_idx)
            REG_X_ORIGIN:  prdata = r_x_origin;
            REG_Y_ORIGIN:  prdata = r_y_origin;
            REG_INV_CELL:  prdata = r_inv_cell;
            REG_GRID_ROWS: prdata = CFG_DW'(r_grid_rows);
            REG_GRID_COLS: prdata = CFG_DW'(r_grid_cols);
            default:       prdata = '0;
        endcase
    end

    // Limits above the grid act as the grid size
    always_comb begin
        if (32'(r_grid_rows) > 32'(GRID_DIM)) begin
            w_rows_lim = LIMIT_W'(GRID_DIM);
        end else begin
            w_rows_lim = r_grid_rows;
        end
        if (32'(r_grid_cols) > 32'(GRID_DIM)) begin
            w_cols_lim = LIMIT_W'(GRID_DIM);
        end else begin
            w_cols_lim = r_grid_cols;
        end
    end
    assign w_dims_zero = (w_rows_lim == '0) || (w_cols_lim == '0);

    // ---------------------------------------------------------------- input side
    assign w_in_acc = s_axis_tvalid & s_axis_tready;

    always_comb begin
        w_in_label = '0;
        for (int i = 0; i < LABEL_BITS; i++) begin
            if (i < int'(IN_LABEL_W)) begin
                w_in_label[i] = s_axis_tdata[18 + i];
            end
        end
    end

    assign w_wr_ok = (32'(s_axis_tdata[8:0]) < 32'(GRID_DIM)) &&
                     (32'(s_axis_tdata[17:9]) < 32'(GRID_DIM));

    // ---------------------------------------------------------------- mapping unit
    always_comb begin
        case (r_ep)
            2'd0:    begin w_coord = r_sx; w_origin = r_x_origin; end
            2'd1:    begin w_coord = r_sy; w_origin = r_y_origin; end
            2'd2:    begin w_coord = r_ex; w_origin = r_x_origin; end
            default: begin w_coord = r_ey; w_origin = r_y_origin; end
        endcase
    end

    assign w_diff = {w_coord[COORD_W-1], w_coord} - {w_origin[COORD_W-1], w_origin};
    assign w_prod = r_diff * r_inv_cell;
    assign w_q    = r_prod[63:16];
    // x endpoints clamp to columns, y endpoints to rows
    assign w_lim  = r_ep[0] ? w_rows_lim : w_cols_lim;

    always_comb begin
        if (r_neg) begin
            w_idx = '0;
        end else if (w_q >= 48'(w_lim)) begin
            w_idx = IW'(w_lim - 1'b1);
        end else begin
            w_idx = IW'(w_q);
        end
    end

    assign w_cells_eq = (r_r1 == r_r2) && (r_c1 == r_c2);

    // ---------------------------------------------------------------- walk datapath
    assign w_step  = (r_stop > r_pos) ? r_pos + 1'b1 : r_pos - 1'b1;
    assign w_raddr = r_along ? {r_r1, w_rd_pos} : {w_rd_pos, r_c1};

    assign w_sum = {1'b0, r_count} +
                   (((r_last == '0) || (r_rdata == '0)) ? (COUNT_W+1)'(1) : (COUNT_W+1)'(2));
    assign w_count_sat = w_sum[COUNT_W] ? COUNT_MAX : w_sum[COUNT_W-1:0];

    assign w_out_free = !r_ov || m_axis_tready;

    // ---------------------------------------------------------------- next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr == '1) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (w_in_acc) begin
                    if (s_axis_tuser[0] == OP_WALK && !w_dims_zero) begin
                        n_state = S_SUB;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_SUB:   n_state = S_MUL;
            S_MUL:   n_state = S_CLAMP;
            S_CLAMP: n_state = (r_ep == 2'd3) ? S_CMP : S_SUB;
            S_CMP:   n_state = w_cells_eq ? S_DONE : S_LOAD;
            S_LOAD:  n_state = S_WALK;
            S_WALK: begin
                if (r_pos == r_stop) n_state = S_DONE;
            end
            S_DONE: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // ---------------------------------------------------------------- control outputs
    always_comb begin
        s_axis_tready = 1'b0;
        w_we          = 1'b0;
        w_waddr       = r_clr;
        w_wdata       = '0;
        w_rd_pos      = w_step;
        n_dv          = 1'b0;
        n_dfirst      = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                w_we = 1'b1;
            end
            S_IDLE: begin
                s_axis_tready = 1'b1;
                w_we    = s_axis_tvalid && (s_axis_tuser[0] == OP_WRITE) && w_wr_ok;
                w_waddr = {IW'(s_axis_tdata[8:0]), IW'(s_axis_tdata[17:9])};
                w_wdata = w_in_label;
            end
            S_LOAD: begin
                // read the start cell to seed the last label
                w_rd_pos = r_pos;
                n_dv     = 1'b1;
                n_dfirst = 1'b1;
            end
            S_WALK: begin
                n_dv = (r_pos != r_stop);
            end
            default: ;
        endcase
    end

    // ---------------------------------------------------------------- grid memory
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_grid[w_waddr] <= w_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_grid[w_raddr];
    end

    // ---------------------------------------------------------------- registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_ep     <= '0;
            r_dv     <= 1'b0;
            r_dfirst <= 1'b0;
            r_ov     <= 1'b0;
            r_count  <= '0;
        end else begin
            r_state  <= n_state;
            r_dv     <= n_dv;
            r_dfirst <= n_dfirst;

            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end

            if (w_in_acc) begin
                r_ep <= '0;
            end else if (r_state == S_CLAMP) begin
                r_ep <= r_ep + 1'b1;
            end

            // fold the cell read last cycle into the running count
            if (w_in_acc) begin
                r_count <= '0;
            end else if (r_dv && !r_dfirst && (r_rdata != r_last)) begin
                r_count <= w_count_sat;
            end

            if (r_state == S_DONE && w_out_free) begin
                r_ov <= 1'b1;
            end else if (m_axis_tready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_sx <= s_axis_tdata[65:34];
            r_sy <= s_axis_tdata[97:66];
            r_ex <= s_axis_tdata[129:98];
            r_ey <= s_axis_tdata[161:130];
        end

        if (r_state == S_SUB) begin
            r_diff <= w_diff[COORD_W-1:0];
            r_neg  <= w_diff[COORD_W];
        end
        if (r_state == S_MUL) begin
            r_prod <= w_prod;
        end
        if (r_state == S_CLAMP) begin
            case (r_ep)
                2'd0:    r_c1 <= w_idx;
                2'd1:    r_r1 <= w_idx;
                2'd2:    r_c2 <= w_idx;
                default: r_r2 <= w_idx;
            endcase
        end

        if (r_state == S_CMP) begin
            r_along <= (r_r1 == r_r2);
            r_pos   <= (r_r1 == r_r2) ? r_c1 : r_r1;
            r_stop  <= (r_r1 == r_r2) ? r_c2 : r_r2;
        end else if (r_state == S_WALK && r_pos != r_stop) begin
            r_pos <= w_step;
        end

        if (r_dv && (r_dfirst || (r_rdata != r_last))) begin
            r_last <= r_rdata;
        end

        if (r_state == S_DONE && w_out_free) begin
            r_out_count <= r_count;
        end
    end

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = OUT_TDATA_W'(r_out_count);

`ifndef NO_ASSERTIONS
    // Read data only comes back while the walk is running
    a_dv_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dv |-> (r_state == S_WALK))
        else $error("cell data pending outside the walk");

    // The grid is written only by the clearing pass or by a write word
    a_we_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> ((r_state == S_CLEAR) || (r_state == S_IDLE)))
        else $error("grid written during a walk");

    // Mapped cells stay inside the active grid
    a_cells_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |-> ((32'(r_c1) < 32'(w_cols_lim)) &&
                                (32'(r_c2) < 32'(w_cols_lim)) &&
                                (32'(r_r1) < 32'(w_rows_lim)) &&
                                (32'(r_r2) < 32'(w_rows_lim))))
        else $error("mapped cell outside the grid");

    // Reaching the end cell finishes the walk
    a_walk_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_WALK) && (r_pos == r_stop)) |=> (r_state == S_DONE))
        else $error("walk did not stop at the end cell");
`endif

endmodule

// ----- tb/gslcc_checker.sv -----
module gslcc_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [gslcc_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    input  logic [gslcc_pkg::IN_TUSER_W-1:0]  i_s_tuser,
    input  logic                              i_s_tvalid,
    input  logic                              i_s_tready,
    input  logic [gslcc_pkg::OUT_TDATA_W-1:0] i_m_tdata,
    input  logic                              i_m_tvalid,
    input  logic                              i_m_tready,
    input  logic                              i_psel,
    input  logic                              i_penable,
    input  logic                              i_pwrite,
    input  logic [gslcc_pkg::CFG_AW-1:0]      i_paddr,
    input  logic [gslcc_pkg::CFG_DW-1:0]      i_pwdata,
    input  logic                              i_pready,
    output int                                o_fail_count,
    output int                                o_pending
);
    import gslcc_pkg::*;

    localparam int GRID_DIM  = 512;
    localparam int COUNT_TOP = 1023;

    // Shadow copy of the label grid; 2-state, so every cell starts blank
    bit [IN_LABEL_W-1:0] label_copy [GRID_DIM*GRID_DIM];

    logic [COORD_W-1:0] x_org;
    logic [COORD_W-1:0] y_org;
    logic [COORD_W-1:0] inv_cell;
    logic [LIMIT_W-1:0] rows_cfg;
    logic [LIMIT_W-1:0] cols_cfg;

    logic [COUNT_W-1:0] counts_due[$];
    int                 errs = 0;

    // Append one expected count at the tail of the queue
    function automatic void queue_count(input logic [COUNT_W-1:0] c);
        counts_due = {counts_due, c};
    endfunction

    function automatic logic [CELL_IDX_W-1:0] map_to_cell(
        input logic [COORD_W-1:0] coord,
        input logic [COORD_W-1:0] origin,
        input logic [LIMIT_W-1:0] limit
    );
        logic signed [COORD_W:0] diff;
        logic [63:0]             prod;
        diff = $signed({coord[COORD_W-1], coord}) - $signed({origin[COORD_W-1], origin});
        if (diff < 0)
            return '0;
        prod = {32'd0, diff[COORD_W-1:0]} * {32'd0, inv_cell};
        if (prod[63:16] >= limit)
            return CELL_IDX_W'(limit - 1'b1);
        return prod[16 +: CELL_IDX_W];
    endfunction

    function automatic logic [COUNT_W-1:0] walk_change_count(
        input logic [COORD_W-1:0] sx,
        input logic [COORD_W-1:0] sy,
        input logic [COORD_W-1:0] ex,
        input logic [COORD_W-1:0] ey
    );
        logic [LIMIT_W-1:0]    rows;
        logic [LIMIT_W-1:0]    cols;
        logic [CELL_IDX_W-1:0] c1, r1, c2, r2;
        logic                  along_row;
        int                    pos, stop, cnt;
        logic [IN_LABEL_W-1:0] last, val;
        rows = (rows_cfg > GRID_DIM) ? LIMIT_W'(GRID_DIM) : rows_cfg;
        cols = (cols_cfg > GRID_DIM) ? LIMIT_W'(GRID_DIM) : cols_cfg;
        if (rows == 0 || cols == 0)
            return '0;
        c1 = map_to_cell(sx, x_org, cols);
        r1 = map_to_cell(sy, y_org, rows);
        c2 = map_to_cell(ex, x_org, cols);
        r2 = map_to_cell(ey, y_org, rows);
        if (r1 == r2 && c1 == c2)
            return '0;
        along_row = (r1 == r2);
        pos  = along_row ? int'(c1) : int'(r1);
        stop = along_row ? int'(c2) : int'(r2);
        last = label_copy[int'(r1)*GRID_DIM + int'(c1)];
        cnt  = 0;
        while (pos != stop) begin
            pos = (stop > pos) ? pos + 1 : pos - 1;
            val = along_row ? label_copy[int'(r1)*GRID_DIM + pos]
                            : label_copy[pos*GRID_DIM + int'(c1)];
            if (val != last) begin
                cnt = cnt + ((last == 0 || val == 0) ? 1 : 2);
                if (cnt > COUNT_TOP)
                    cnt = COUNT_TOP;
                last = val;
            end
        end
        return cnt[COUNT_W-1:0];
    endfunction

    always @(posedge i_clk) begin
        logic [COUNT_W-1:0] want;
        logic [COUNT_W-1:0] got;
        if (!i_rst_n) begin
            x_org    <= '0;
            y_org    <= '0;
            inv_cell <= 32'd65536;
            rows_cfg <= 10'd512;
            cols_cfg <= 10'd512;
            counts_due.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_reg_idx'(i_paddr[4:2]))
                    REG_X_ORIGIN:  x_org    <= i_pwdata;
                    REG_Y_ORIGIN:  y_org    <= i_pwdata;
                    REG_INV_CELL:  inv_cell <= i_pwdata;
                    REG_GRID_ROWS: rows_cfg <= i_pwdata[LIMIT_W-1:0];
                    REG_GRID_COLS: cols_cfg <= i_pwdata[LIMIT_W-1:0];
                    default: ;
                endcase
            end
            // Retire the oldest count before queuing a new one
            if (i_m_tvalid && i_m_tready) begin
                got = i_m_tdata[COUNT_W-1:0];
                if (counts_due.size() == 0) begin
                    $error("change_count: expected none, actual %0d", got);
                    errs++;
                end else begin
                    want = counts_due.pop_front();
                    if (got !== want) begin
                        $error("change_count: expected %0d, actual %0d", want, got);
                        errs++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                if (i_s_tuser[0] == OP_WRITE) begin
                    label_copy[int'(i_s_tdata[8:0])*GRID_DIM + int'(i_s_tdata[17:9])] =
                        i_s_tdata[33:18];
                    queue_count('0);
                end else begin
                    queue_count(walk_change_count(i_s_tdata[65:34],
                        i_s_tdata[97:66], i_s_tdata[129:98], i_s_tdata[161:130]));
                end
            end
        end
        o_pending    <= counts_due.size();
        o_fail_count <= errs;
    end

endmodule

// ----- tb/tb_top.sv -----
module tb_top;
    import gslcc_pkg::*;

    // Register indexes past the last defined one; writes there must do nothing
    localparam logic [2:0] REG_SPARE_LO = 3'd5;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;

    localparam int N_PHASES   = 10;
    localparam int PHASE_LEN  = 80;
    localparam int HOLD_LEN   = 1500;
    localparam int TAIL_WAIT  = 600;
    localparam int HOLD_PHASE = 5;
    localparam int PAUSE_PHASE = 7;
    localparam int CALM_PHASE = 3;

    logic                   i_clk;
    logic                   i_rst_n       = 1'b0;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic [IN_TUSER_W-1:0]  s_axis_tuser  = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic                   psel          = 1'b0;
    logic                   penable       = 1'b0;
    logic                   pwrite        = 1'b0;
    logic [CFG_AW-1:0]      paddr         = '0;
    logic [CFG_DW-1:0]      pwdata        = '0;
    logic [CFG_DW-1:0]      prdata;
    logic                   pready;

    int fail_count;
    int pending;

    // Idle rates in percent, and the receiver hold-off request
    int   tx_idle_pct = 10;
    int   rx_idle_pct = 10;
    logic hold_req    = 1'b0;
    int   hold_left   = 0;

    // Current settings, mirrored here to aim endpoints at the grid in use
    logic [COORD_W-1:0] cfg_x;
    logic [COORD_W-1:0] cfg_y;
    logic [COORD_W-1:0] cfg_inv;
    int                 eff_rows;
    int                 eff_cols;
    int                 span;

    grid_segment_label_change_count_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    gslcc_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tuser    (s_axis_tuser),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // Guard against a hung run, long enough to also cover the grid clear after reset
    initial begin
        #16_000_000;
        $display("status: fail");
        $finish;
    end

    // Receiver: random stalls, plus one long hold-off counted here when requested
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end else if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_LEN;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    // APB write: setup, then access; the register lands on the access edge
    task automatic apb_write(input logic [2:0] idx, input logic [CFG_DW-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Write all five registers and refresh the local view of the grid geometry
    task automatic set_config(
        input logic [COORD_W-1:0] xo,
        input logic [COORD_W-1:0] yo,
        input logic [COORD_W-1:0] inv,
        input logic [LIMIT_W-1:0] nr,
        input logic [LIMIT_W-1:0] nc
    );
        apb_write(REG_X_ORIGIN, xo);
        apb_write(REG_Y_ORIGIN, yo);
        apb_write(REG_INV_CELL, inv);
        apb_write(REG_GRID_ROWS, {22'd0, nr});
        apb_write(REG_GRID_COLS, {22'd0, nc});
        cfg_x    = xo;
        cfg_y    = yo;
        cfg_inv  = inv;
        eff_rows = (nr > 512) ? 512 : ((nr == 0) ? 1 : int'(nr));
        eff_cols = (nc > 512) ? 512 : ((nc == 0) ? 1 : int'(nc));
        span     = (inv == 0 || inv >= 32'd65536) ? 1 : int'(32'd65536 / inv);
    endtask

    // Offer one word and hold it until taken. Valid stays high afterwards so
    // back-to-back words need no gap; callers drop it before any wait.
    task automatic push_word(input logic op, input logic [IN_TDATA_W-1:0] data);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= data;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Endpoint fields of a write word are don't-care: fill them with noise
    task automatic send_write(
        input logic [CELL_IDX_W-1:0] row,
        input logic [CELL_IDX_W-1:0] col,
        input logic [IN_LABEL_W-1:0] lbl
    );
        logic [COORD_W-1:0] n0, n1, n2, n3;
        n0 = $urandom();
        n1 = $urandom();
        n2 = $urandom();
        n3 = $urandom();
        push_word(OP_WRITE, {6'd0, n3, n2, n1, n0, lbl, col, row});
    endtask

    // Cell fields of a walk word are don't-care as well
    task automatic send_walk(
        input logic [COORD_W-1:0] sx,
        input logic [COORD_W-1:0] sy,
        input logic [COORD_W-1:0] ex,
        input logic [COORD_W-1:0] ey
    );
        logic [CELL_IDX_W-1:0] nr, nc;
        logic [IN_LABEL_W-1:0] nl;
        nr = $urandom();
        nc = $urandom();
        nl = $urandom();
        push_word(OP_WALK, {6'd0, ey, ex, sy, sx, nl, nc, nr});
    endtask

    // Drop valid and hold until every queued count has come back
    task automatic drain;
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // Mostly a point a few cells around the grid in use; sometimes full-range noise
    function automatic logic [COORD_W-1:0] rand_coord(input logic [COORD_W-1:0] origin,
                                                      input int n);
        int off;
        if ($urandom_range(0, 9) == 0)
            return $urandom();
        off = int'($urandom_range(0, span * (n + 3))) - 2 * span;
        return origin + off;
    endfunction

    // Blanks and a few small labels make equal neighbors common
    function automatic logic [IN_LABEL_W-1:0] rand_label;
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 3)
            return '0;
        if (pick < 7)
            return IN_LABEL_W'($urandom_range(1, 3));
        return $urandom();
    endfunction

    task automatic random_config;
        logic [COORD_W-1:0] xo, yo, inv;
        logic [LIMIT_W-1:0] nr, nc;
        case ($urandom_range(0, 5))
            0: xo = '0;
            1: xo = 32'h8000_0000;
            2: xo = 32'h7FFF_FFFF;
            3: xo = $urandom();
            default: xo = $urandom_range(0, 2000) - 1000;
        endcase
        case ($urandom_range(0, 5))
            0: yo = '0;
            1: yo = 32'h8000_0000;
            2: yo = 32'h7FFF_FFFF;
            3: yo = $urandom();
            default: yo = $urandom_range(0, 2000) - 1000;
        endcase
        case ($urandom_range(0, 9))
            0: inv = 32'd65536;
            1: inv = 32'd16384;
            2: inv = 32'd32768;
            3: inv = 32'd131072;
            4: inv = 32'd1;
            5: inv = 32'hFFFF_FFFF;
            6: inv = '0;
            default: inv = $urandom_range(4096, 262144);
        endcase
        case ($urandom_range(0, 9))
            0: nr = 10'd512;
            1: nr = 10'd1;
            2: nr = 10'd0;
            3: nr = 10'd1023;
            default: nr = $urandom_range(2, 48);
        endcase
        case ($urandom_range(0, 9))
            0: nc = 10'd512;
            1: nc = 10'd1;
            2: nc = 10'd0;
            3: nc = 10'd700;
            default: nc = $urandom_range(2, 48);
        endcase
        set_config(xo, yo, inv, nr, nc);
    endtask

    task automatic random_item;
        logic [COORD_W-1:0]    sx, sy, ex, ey;
        logic [CELL_IDX_W-1:0] row, col;
        int                    shape;
        if ($urandom_range(0, 1) == 0) begin
            // Aim most writes at the rows and columns the walks can reach
            row = ($urandom_range(0, 3) == 0) ? CELL_IDX_W'($urandom_range(0, 511))
                                              : CELL_IDX_W'($urandom_range(0, eff_rows - 1));
            col = ($urandom_range(0, 3) == 0) ? CELL_IDX_W'($urandom_range(0, 511))
                                              : CELL_IDX_W'($urandom_range(0, eff_cols - 1));
            send_write(row, col, rand_label());
        end else begin
            sx = rand_coord(cfg_x, eff_cols);
            sy = rand_coord(cfg_y, eff_rows);
            ex = rand_coord(cfg_x, eff_cols);
            ey = rand_coord(cfg_y, eff_rows);
            shape = $urandom_range(0, 9);
            // Force a shared row often, else almost every walk runs down a column
            if (shape < 4)
                ey = sy;
            else if (shape < 6)
                ex = sx;
            send_walk(sx, sy, ex, ey);
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Start from the reset settings: origin 0, unit cells, full grid
        set_config('0, '0, 32'd65536, 10'd512, 10'd512);

        // Label extremes, a blank, repeated labels down column 0
        send_write(9'd0, 9'd0, 16'hFFFF);
        send_write(9'd0, 9'd1, 16'h0000);
        send_write(9'd0, 9'd2, 16'd7);
        send_write(9'd511, 9'd511, 16'd1);
        send_write(9'd1, 9'd0, 16'd5);
        send_write(9'd2, 9'd0, 16'd5);
        send_write(9'd3, 9'd0, 16'd9);

        // Same cell, along a row both ways, down a column, a diagonal
        send_walk(32'd0, 32'd0, 32'd0, 32'd0);
        send_walk(32'd0, 32'd0, 32'd5, 32'd0);
        send_walk(32'd5, 32'd0, 32'd0, 32'd0);
        send_walk(32'd0, 32'd0, 32'd0, 32'd4);
        send_walk(32'd0, 32'd4, 32'd9, 32'd0);

        // Coordinate extremes: negative maps to 0, huge clamps to the last cell
        send_walk(32'h8000_0000, 32'd0, 32'h7FFF_FFFF, 32'd0);
        send_walk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        send_write(9'd511, 9'd0, 16'h8000);
        send_walk(32'd0, 32'd0, 32'd0, 32'h7FFF_FFFF);
        drain();

        // No rows in use: any walk gives zero
        set_config('0, '0, 32'd65536, 10'd0, 10'd512);
        send_walk(32'd0, 32'd0, 32'd5, 32'd0);
        drain();

        // Small grid: a write beyond it is still stored; walk clamps at column 3
        set_config('0, '0, 32'd65536, 10'd4, 10'd4);
        send_write(9'd10, 9'd10, 16'd2);
        send_walk(32'd0, 32'd0, 32'd100, 32'd0);
        drain();

        // Sizes above the grid act as the full grid; the earlier write shows up
        set_config('0, '0, 32'd65536, 10'd1023, 10'd600);
        apb_write(REG_SPARE_LO, 32'h0000_0001);
        apb_write(REG_SPARE_HI, 32'hFFFF_FFFF);
        send_walk(32'd0, 32'd10, 32'd20, 32'd10);
        drain();

        // Zero reciprocal folds every endpoint onto cell 0
        set_config('0, '0, '0, 10'd512, 10'd512);
        send_walk(32'h8000_0000, 32'd3, 32'h7FFF_FFFF, 32'd400);
        drain();

        // Extreme origins and reciprocal, one column
        set_config(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 10'd512, 10'd1);
        send_walk(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'd0);
        send_walk(32'd0, 32'd0, 32'h8000_0000, 32'h8000_0001);

        for (int ph = 0; ph < N_PHASES; ph++) begin
            drain();
            random_config();
            tx_idle_pct = (ph == CALM_PHASE) ? 0 : 10;
            rx_idle_pct = (ph == CALM_PHASE) ? 0 : 10;
            for (int i = 0; i < PHASE_LEN; i++) begin
                // Starve the output for a long stretch while words keep coming
                if (ph == HOLD_PHASE && i == 5)
                    hold_req = 1'b1;
                // Let the pipeline run dry mid-phase, then resume
                if (ph == PAUSE_PHASE && i == PHASE_LEN / 2)
                    drain();
                random_item();
            end
        end

        drain();
        repeat (TAIL_WAIT) @(posedge i_clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
